### rtl/sqtc_pkg.sv
// Shared types and constants for the square tone channel controller.
// No dependencies; compile first.
package sqtc_pkg;

   localparam int unsigned DIV_W      = 18;
   localparam int unsigned DIVISOR_W  = 16;
   localparam int unsigned DIV_STEPS  = DIV_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int unsigned FRAMES_W   = 12;
   localparam int unsigned PERIOD_W   = 11;
   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned DUR_W       = 17;
   localparam int unsigned FRM_SHIFT   = 25;
   localparam int unsigned FRM_RECIP_W = 26;
   localparam int unsigned FRM_PROD_W  = DUR_W + FRM_RECIP_W;
   localparam int unsigned FRM_QUO_W   = FRM_PROD_W - FRM_SHIFT;

   localparam logic [1:0] REQ_TONE = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_STOP = 2'd2;

   localparam logic [1:0] CMD_TONE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;

   localparam logic [1:0] SEL_SWEEP = 2'd0;
   localparam logic [1:0] SEL_ENV   = 2'd1;
   localparam logic [1:0] SEL_FREQ  = 2'd2;

   localparam logic [15:0]         ENV_RESET   = 16'hF080;
   localparam logic [15:0]         RESTART_BIT = 16'h8000;
   localparam logic [15:0]         HZ_MIN      = 16'd64;
   localparam logic [15:0]         HZ_MAX      = 16'd20000;
   localparam logic [DIV_W-1:0]    PERIOD_NUM  = 18'd131072;
   localparam logic [FRAMES_W-1:0] PERIOD_BASE = 12'd2048;
   localparam logic [FRAMES_W-1:0] FRAMES_MAX  = 12'd4095;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] freq_hz;
      logic [15:0] duration_ms;
   } cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/sqtc_if.sv
// Valid/ready channel interfaces for requests and register-write responses.
// No dependencies.
interface sqtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] freq_hz;
   logic [15:0] duration_ms;

   modport source (output valid, req_type, freq_hz, duration_ms, input ready);
   modport sink (input valid, req_type, freq_hz, duration_ms, output ready);
endinterface

interface sqtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_select;
   logic [15:0] reg_value;
   logic        tone_active;
   logic        last;

   modport source (output valid, reg_select, reg_value, tone_active, last, input ready);
   modport sink (input valid, reg_select, reg_value, tone_active, last, output ready);
endinterface

### rtl/sqtc_front.sv
// Request front end: accepts requests and classifies them into commands.
// Depends on sqtc_pkg and sqtc_req_if.
module sqtc_front (
   sqtc_req_if.sink           req_bus,
   input  logic               fifo_full,
   output logic               push,
   output sqtc_pkg::cmd_type  push_cmd
);
   import sqtc_pkg::*;

   logic keep;

   assign req_bus.ready = !fifo_full;

   always_comb begin
      keep          = 1'b1;
      push_cmd.freq_hz     = req_bus.freq_hz;
      push_cmd.duration_ms = req_bus.duration_ms;
      unique case (req_bus.req_type)
         REQ_TONE: begin
            if (req_bus.freq_hz == 16'd0 || req_bus.duration_ms == 16'd0) begin
               push_cmd.kind = CMD_STOP;
            end else begin
               push_cmd.kind = CMD_TONE;
            end
         end
         REQ_TICK: push_cmd.kind = CMD_TICK;
         REQ_STOP: push_cmd.kind = CMD_STOP;
         default: begin
            push_cmd.kind = CMD_STOP;
            keep          = 1'b0;
         end
      endcase
   end

   assign push = req_bus.valid && !fifo_full && keep;

endmodule

### rtl/sqtc_fifo.sv
// Short command queue between the front end and the back end.
// Depends on sqtc_pkg.
module sqtc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sqtc_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output sqtc_pkg::cmd_type  pop_cmd
);
   import sqtc_pkg::*;

   cmd_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/sqtc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sqtc_pkg.
module sqtc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sqtc_pkg::div_req_type div_req,
   output sqtc_pkg::div_rsp_type div_rsp
);
   import sqtc_pkg::*;

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### rtl/sqtc_back.sv
// Back end: tone state, period and frame computation, register-write sequencing.
// Depends on sqtc_pkg and sqtc_rsp_if; drives the divider in sqtc_div through its ports.
module sqtc_back #(
   parameter int unsigned FRAME_MS = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   input  logic                  fifo_empty,
   input  sqtc_pkg::cmd_type     pop_cmd,
   output logic                  pop,
   output sqtc_pkg::div_req_type div_req,
   input  sqtc_pkg::div_rsp_type div_rsp,
   sqtc_rsp_if.source            rsp_bus
);
   import sqtc_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DIV_PER = 2'd1;
   localparam logic [1:0] ST_EMIT    = 2'd2;

   localparam logic [FRM_RECIP_W-1:0] FRAME_RECIP =
      FRM_RECIP_W'(((32'd1 << FRM_SHIFT) + FRAME_MS - 1) / FRAME_MS);

   logic [1:0]          state_ff, state_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic                tone_on_ff, tone_on_in;
   logic [15:0]         env_ff, env_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                seq_tone_ff, seq_tone_in;
   logic [1:0]          idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_sel_ff, rsp_sel_in;
   logic [15:0]         rsp_value_ff, rsp_value_in;
   logic                rsp_active_ff, rsp_active_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic [15:0]           hz_clamped;
   logic [FRAMES_W-1:0]   n_full;
   logic [FRM_PROD_W-1:0] frm_prod;
   logic [FRM_QUO_W-1:0]  frm_quo;
   logic [1:0]            emit_sel;
   logic [15:0]           emit_value;
   logic                  emit_last;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      if (pop_cmd.freq_hz < HZ_MIN) begin
         hz_clamped = HZ_MIN;
      end else if (pop_cmd.freq_hz > HZ_MAX) begin
         hz_clamped = HZ_MAX;
      end else begin
         hz_clamped = pop_cmd.freq_hz;
      end
   end

   assign n_full = PERIOD_BASE - div_rsp.quotient[FRAMES_W-1:0];

   assign frm_prod = FRM_PROD_W'(dur_ff) * FRM_PROD_W'(FRAME_RECIP);
   assign frm_quo  = frm_prod[FRM_PROD_W-1:FRM_SHIFT];

   always_comb begin
      emit_sel   = SEL_FREQ;
      emit_value = '0;
      emit_last  = 1'b1;
      if (seq_tone_ff) begin
         case (idx_ff)
            2'd0: begin
               emit_sel  = SEL_SWEEP;
               emit_last = 1'b0;
            end
            2'd1: begin
               emit_sel   = SEL_ENV;
               emit_value = env_ff;
               emit_last  = 1'b0;
            end
            default: emit_value = RESTART_BIT | {5'd0, period_ff};
         endcase
      end else if (idx_ff == 2'd0) begin
         emit_sel  = SEL_ENV;
         emit_last = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      frames_in     = frames_ff;
      tone_on_in    = tone_on_ff;
      env_in        = csr_we ? csr_wdata : env_ff;
      dur_in        = dur_ff;
      period_in     = period_ff;
      seq_tone_in   = seq_tone_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_sel_in    = rsp_sel_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = PERIOD_NUM;
      div_req.divisor  = hz_clamped;
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               pop    = 1'b1;
               idx_in = '0;
               unique case (pop_cmd.kind)
                  CMD_TONE: begin
                     dur_in        = DUR_W'(pop_cmd.duration_ms) + DUR_W'(FRAME_MS - 1);
                     div_req.start = 1'b1;
                     state_in      = ST_DIV_PER;
                  end
                  CMD_TICK: begin
                     if (tone_on_ff) begin
                        if (frames_ff <= FRAMES_W'(1)) begin
                           frames_in   = '0;
                           tone_on_in  = 1'b0;
                           seq_tone_in = 1'b0;
                           state_in    = ST_EMIT;
                        end else begin
                           frames_in = frames_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     frames_in   = '0;
                     tone_on_in  = 1'b0;
                     seq_tone_in = 1'b0;
                     state_in    = ST_EMIT;
                  end
               endcase
            end
         end
         ST_DIV_PER: begin
            if (div_rsp.done) begin
               period_in   = n_full[PERIOD_W-1:0];
               frames_in   = (frm_quo > FRM_QUO_W'(FRAMES_MAX)) ?
                             FRAMES_MAX : frm_quo[FRAMES_W-1:0];
               tone_on_in  = 1'b1;
               seq_tone_in = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sel_in    = emit_sel;
               rsp_value_in  = emit_value;
               rsp_active_in = seq_tone_ff;
               rsp_last_in   = emit_last;
               idx_in        = idx_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= '0;
         tone_on_ff   <= 1'b0;
         env_ff       <= ENV_RESET;
         rsp_valid_ff <= 1'b0;
         seq_tone_ff  <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         tone_on_ff   <= tone_on_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_tone_ff  <= seq_tone_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff        <= dur_in;
      period_ff     <= period_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.reg_select  = rsp_sel_ff;
   assign rsp_bus.reg_value   = rsp_value_ff;
   assign rsp_bus.tone_active = rsp_active_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

### rtl/square_tone_channel_controller.sv
// Square tone channel controller top level.
// Depends on sqtc_pkg, sqtc_if, sqtc_front, sqtc_fifo, sqtc_div and sqtc_back.
//
// Requests arrive on req_bus (tone, frame tick or stop) and turn into channel
// register writes on rsp_bus, one write per response, with last marking the
// final write of a request. csr_we/csr_wdata load the envelope word used when
// a tone starts; write it only while the block is idle.
// A tone request runs one 18-step restoring division for the period while a
// reciprocal multiply gives the frame count, and then its writes leave one
// per cycle while the receiver is ready. A stop, or a tick that ends the
// tone, goes straight to the emit state for its writes; other ticks retire
// with no write. A two-entry queue lets requests be taken while the back end
// works; req_bus.ready drops only when it is full. Reset clears the queue,
// stops the tone, zeroes the frame count and loads the envelope word with
// 0xF080. When the receiver stalls, the pending write holds in the output
// register and the sequencer waits behind it.
module square_tone_channel_controller #(
   parameter int unsigned FRAME_MS = 17
) (
   input  logic        clock,
   input  logic        reset,
   sqtc_req_if.sink    req_bus,
   sqtc_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import sqtc_pkg::*;

   logic        fifo_full;
   logic        fifo_empty;
   logic        push;
   logic        pop;
   cmd_type     push_cmd;
   cmd_type     pop_cmd;
   div_req_type div_req;
   div_rsp_type div_rsp;

   sqtc_front u_front (
      .req_bus   (req_bus),
      .fifo_full (fifo_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   sqtc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .empty    (fifo_empty),
      .pop_cmd  (pop_cmd)
   );

   sqtc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   sqtc_back #(
      .FRAME_MS (FRAME_MS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fifo_empty (fifo_empty),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_bus    (rsp_bus)
   );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for square_tone_channel_controller: queued tone, tick
// and stop requests feed a clocked driver, and a clocked monitor checks each write.
// Depends on sqtc_pkg, sqtc_if and the controller RTL.
module tb_top;
   import sqtc_pkg::*;

   localparam int unsigned FRAME_MS     = 17;
   localparam logic [1:0]  REQ_UNUSED   = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned FINAL_WAIT   = 60000;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned MAX_SHOWN    = 10;

   typedef struct packed {
      logic [1:0]  reg_select;
      logic [15:0] reg_value;
      logic        tone_active;
      logic        last;
   } chan_write_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_we    = 1'b0;
   logic [15:0] csr_wdata = '0;

   sqtc_req_if req_bus ();
   sqtc_rsp_if rsp_bus ();

   square_tone_channel_controller #(.FRAME_MS(FRAME_MS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   cmd_type        pending_requests[$];
   chan_write_type expected_writes[$];

   logic [11:0] frames_left_q = '0;
   logic        tone_on_q     = 1'b0;
   logic [15:0] envelope_q    = ENV_RESET;

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   logic        no_idle   = 1'b0;
   int unsigned req_gap   = 0;
   int unsigned rsp_gap   = 0;
   int unsigned hold_left = 0;
   int unsigned holds_asked  = 0;
   int unsigned holds_served = 0;

   int unsigned cycle_count    = 0;
   int unsigned mismatches     = 0;
   int unsigned requests_taken = 0;
   int unsigned writes_checked = 0;
   int unsigned tones_started  = 0;
   int unsigned stops_issued   = 0;
   int unsigned ticks_ended    = 0;
   int unsigned env_settings   = 0;
   int unsigned queued_count   = 0;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic clear_channel();
      frames_left_q = '0;
      tone_on_q     = 1'b0;
      expected_writes.push_back('{SEL_ENV, 16'h0000, 1'b0, 1'b0});
      expected_writes.push_back('{SEL_FREQ, 16'h0000, 1'b0, 1'b1});
      stops_issued++;
   endtask

   task automatic predict_writes(input cmd_type c);
      int unsigned hz;
      int unsigned period;
      int unsigned frames;
      case (c.kind)
         REQ_TONE: begin
            if (c.freq_hz == 0 || c.duration_ms == 0) begin
               clear_channel();
            end else begin
               hz = c.freq_hz;
               if (hz < HZ_MIN) hz = HZ_MIN;
               if (hz > HZ_MAX) hz = HZ_MAX;
               period = 2048 - 131072 / hz;
               if (period > 2047) period = 2047;
               frames = (c.duration_ms + FRAME_MS - 1) / FRAME_MS;
               if (frames < 1) frames = 1;
               if (frames > FRAMES_MAX) frames = FRAMES_MAX;
               frames_left_q = frames[11:0];
               tone_on_q     = 1'b1;
               expected_writes.push_back('{SEL_SWEEP, 16'h0000, 1'b1, 1'b0});
               expected_writes.push_back('{SEL_ENV, envelope_q, 1'b1, 1'b0});
               expected_writes.push_back('{SEL_FREQ, RESTART_BIT | {5'b0, period[10:0]},
                                           1'b1, 1'b1});
               tones_started++;
            end
         end
         REQ_TICK: begin
            if (tone_on_q) begin
               if (frames_left_q <= 1) begin
                  clear_channel();
                  ticks_ended++;
               end else begin
                  frames_left_q = frames_left_q - 1'b1;
               end
            end
         end
         REQ_STOP: begin
            clear_channel();
         end
         default: begin
         end
      endcase
   endtask

   task automatic note_mismatch(input string what, input chan_write_type want,
                                input chan_write_type got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display({"%0t: %s: expected sel=%0d value=%h active=%b last=%b, ",
                   "got sel=%0d value=%h active=%b last=%b"},
                  $realtime, what, want.reg_select, want.reg_value, want.tone_active,
                  want.last, got.reg_select, got.reg_value, got.tone_active, got.last);
   endtask

   // Check the oldest expected write before predicting for a new request.
   always @(posedge clock) begin
      chan_write_type got;
      chan_write_type want;
      cmd_type        taken;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      rsp_taken <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.reg_select, rsp_bus.reg_value, rsp_bus.tone_active, rsp_bus.last};
         writes_checked++;
         if (expected_writes.size() == 0) begin
            note_mismatch("unexpected write", '0, got);
         end else begin
            want = expected_writes.pop_front();
            if (got.reg_select !== want.reg_select || got.reg_value !== want.reg_value ||
                got.tone_active !== want.tone_active || got.last !== want.last)
               note_mismatch("write mismatch", want, got);
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken = '{req_bus.req_type, req_bus.freq_hz, req_bus.duration_ms};
         requests_taken++;
         predict_writes(taken);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Request driver: hold until taken, then idle or offer the next request.
   always @(negedge clock) begin
      cmd_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
      end else if (req_gap != 0) begin
         req_bus.valid <= 1'b0;
         req_gap       <= req_gap - 1;
      end else if (pending_requests.size() != 0) begin
         next_req = pending_requests.pop_front();
         req_bus.valid       <= 1'b1;
         req_bus.req_type    <= next_req.kind;
         req_bus.freq_hz     <= next_req.freq_hz;
         req_bus.duration_ms <= next_req.duration_ms;
         req_gap             <= pick_gap();
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Response receiver: random stalls plus long hold-offs on request.
   always @(negedge clock) begin
      int unsigned g;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= LONG_HOLD;
         holds_served  <= holds_asked;
      end else if (rsp_gap != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= rsp_gap - 1;
      end else if (rsp_taken) begin
         g = pick_gap();
         if (g != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap       <= g - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("square_tone_channel_controller regression: fail");
      $finish;
   end

   task automatic add_request(input logic [1:0] kind, input logic [15:0] freq,
                              input logic [15:0] dur);
      pending_requests.push_back('{kind, freq, dur});
      if (kind != REQ_UNUSED) queued_count++;
   endtask

   function automatic logic [15:0] pick_freq();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(1, 63));
         1:       return 16'($urandom_range(20001, 65535));
         2:       return 16'($urandom_range(64, 200));
         3:       return 16'($urandom);
         default: return 16'($urandom_range(64, 20000));
      endcase
   endfunction

   task automatic add_tone_sequence();
      int unsigned ticks;
      logic [15:0] dur;
      if ($urandom_range(0, 9) == 0) dur = 16'($urandom);
      else dur = 16'($urandom_range(1, 120));
      add_request(REQ_TONE, pick_freq(), dur);
      ticks = $urandom_range(0, 9);
      repeat (ticks) add_request(REQ_TICK, 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 3) == 0) add_request(REQ_STOP, 16'($urandom), 16'($urandom));
   endtask

   task automatic add_noise();
      case ($urandom_range(0, 3))
         0: add_request(REQ_TONE, 16'h0000, 16'($urandom));
         1: add_request(REQ_TONE, 16'($urandom), 16'h0000);
         default: add_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      endcase
   endtask

   task automatic queue_random(input int unsigned count);
      int unsigned target;
      target = queued_count + count;
      while (queued_count < target) begin
         if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
         if ($urandom_range(0, 4) == 0) add_noise();
         else add_tone_sequence();
      end
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_bus.valid || expected_writes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_envelope(input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we     <= 1'b0;
      envelope_q  = value;
      env_settings++;
   endtask

   initial begin
      int unsigned waited;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_TONE;
      req_bus.freq_hz     = '0;
      req_bus.duration_ms = '0;
      rsp_bus.ready       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_request(REQ_TICK, 16'h0000, 16'h0000);
      add_request(REQ_STOP, 16'h0000, 16'h0000);
      add_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
      add_request(REQ_TONE, 16'd1, 16'd1);
      add_request(REQ_TICK, 16'h0000, 16'h0000);
      add_request(REQ_TONE, 16'd63, 16'd17);
      add_request(REQ_TONE, 16'd64, 16'd18);
      add_request(REQ_TICK, 16'h0000, 16'h0000);
      add_request(REQ_TICK, 16'hFFFF, 16'hFFFF);
      add_request(REQ_TONE, 16'hFFFF, 16'hFFFF);
      add_request(REQ_TONE, 16'd20000, 16'd100);
      add_request(REQ_TONE, 16'd20001, 16'd34);
      add_request(REQ_TONE, 16'd0, 16'd100);
      add_request(REQ_TONE, 16'd440, 16'd0);
      add_request(REQ_TICK, 16'h0000, 16'h0000);
      add_request(REQ_TONE, 16'd65, 16'd35);
      repeat (3) add_request(REQ_TICK, 16'h0000, 16'h0000);
      add_request(REQ_STOP, 16'hFFFF, 16'hFFFF);
      add_request(REQ_TONE, 16'hAAAA, 16'h5555);
      add_request(REQ_TONE, 16'h5555, 16'hAAAA);
      add_request(REQ_STOP, 16'h0000, 16'h0000);
      queue_random(35);
      wait_idle();

      write_envelope(16'h0000);
      queue_random(40);
      wait_idle();

      no_idle = 1'b1;
      write_envelope(16'hFFFF);
      holds_asked++;
      repeat (12) add_request(REQ_TONE, pick_freq(), 16'($urandom_range(1, 60)));
      wait_idle();
      no_idle = 1'b0;
      queue_random(30);
      wait_idle();

      write_envelope(16'($urandom));
      queue_random(40);
      wait_idle();

      write_envelope(16'h0F7F);
      queue_random(30);

      waited = 0;
      while ((pending_requests.size() != 0 || req_bus.valid || expected_writes.size() != 0)
             && waited < FINAL_WAIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_writes.size() != 0) begin
         mismatches += expected_writes.size();
         $display("%0d expected register writes never arrived", expected_writes.size());
      end

      $display({"Ran %0d requests over %0d envelope settings: %0d tones, ",
                "%0d stop sequences, %0d tick-ended tones"},
               requests_taken, env_settings + 1, tones_started, stops_issued, ticks_ended);
      $display("Checked %0d register writes in %0d cycles, %0d mismatches",
               writes_checked, cycle_count, mismatches);
      if (mismatches == 0)
         $display("square_tone_channel_controller regression: pass");
      else
         $display("square_tone_channel_controller regression: fail");
      $finish;
   end

endmodule
